// File: design/alm_pkg.sv
// Shared types and codes for the array linked list manager.
// Holds request/status codes, the sequencer state type and field widths.
// No dependencies.
package alm_pkg;

    localparam int REQ_W  = 3;
    localparam int VAL_W  = 64;
    localparam int SLOT_W = 4;
    localparam int POS_W  = 4;
    localparam int ST_W   = 2;

    typedef enum logic [REQ_W-1:0] {
        REQ_INS_AFTER = 3'd0,
        REQ_INS_TAIL  = 3'd1,
        REQ_EXT_SLOT  = 3'd2,
        REQ_EXT_HEAD  = 3'd3,
        REQ_EXT_TAIL  = 3'd4,
        REQ_LOCATE    = 3'd5
    } t_req;

    typedef enum logic [ST_W-1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2,
        ST_BAD   = 2'd3
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DEC,
        S_INS_F,
        S_INS_A,
        S_INS_N,
        S_INS_W,
        S_EXT_N,
        S_EXT_P,
        S_EXT_Q,
        S_LOC,
        S_LOC_NXT,
        S_LOC_VAL,
        S_FIN
    } t_state;

endpackage

// File: design/alm_req_if.sv
// Request channel of the list manager: valid/ready plus request payload.
// Depends on alm_pkg for field widths.
interface alm_req_if import alm_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [REQ_W-1:0]  req_type;
    logic [VAL_W-1:0]  data_value;
    logic [SLOT_W-1:0] slot;
    logic [POS_W-1:0]  position;

    modport source (output valid, req_type, data_value, slot, position, input ready);
    modport sink   (input valid, req_type, data_value, slot, position, output ready);
endinterface

// File: design/alm_rsp_if.sv
// Response channel of the list manager: valid/ready plus result payload.
// Depends on alm_pkg for field widths.
interface alm_rsp_if import alm_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [VAL_W-1:0]  out_value;
    logic [SLOT_W-1:0] out_slot;
    logic [ST_W-1:0]   status;

    modport source (output valid, out_value, out_slot, status, input ready);
    modport sink   (input valid, out_value, out_slot, status, output ready);
endinterface

// File: design/array_linked_list_manager.sv
// Channel  Dir  Payload                              Handshake
// i_req    in   req_type, data_value, slot, position valid/ready
// o_rsp    out  out_value, out_slot, status          valid/ready
//
// One request at a time; ready is high only while the sequencer is idle.
// The single read port of the link memory paces every request: each link touched
// is read, patched and written back one step at a time. Reset (synchronous,
// active low) takes effect at the next clock edge; untouched slots read as the
// initial free chain through a high-water mark, so no clearing pass runs.
// A result waiting in the output register holds the sequencer in its final state.
module array_linked_list_manager import alm_pkg::*; #(
    parameter int NODE_SLOTS = 16,
    parameter int DATA_BITS  = 64
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    alm_req_if.sink   i_req,
    alm_rsp_if.source o_rsp
);
    localparam int SW   = $clog2(NODE_SLOTS);
    localparam int LW   = 2 * SW;
    localparam int CW   = $clog2(NODE_SLOTS);
    localparam int HW   = $clog2(NODE_SLOTS + 1);
    localparam int IU   = (NODE_SLOTS < 16) ? NODE_SLOTS : 16;
    localparam int IUW  = $clog2(IU);

    t_state r_state, n_state;

    // request
    logic [REQ_W-1:0]     r_type;
    logic [DATA_BITS-1:0] r_data;
    logic [SLOT_W-1:0]    r_slot;
    logic [POS_W-1:0]     r_pos;

    // list state
    logic [SW-1:0] r_head, r_tail, r_free;
    logic [CW-1:0] r_count;
    logic [HW-1:0] r_hwm;
    logic [IU-1:0] r_iu;

    // working registers
    logic [SW-1:0]    r_a, r_n, r_pr, r_nfree, r_ptr;
    logic             r_fresh;
    logic [POS_W-1:0] r_steps;
    logic [VAL_W-1:0] r_res_value;
    logic [SLOT_W-1:0] r_res_slot;
    t_status          r_res_status;

    // output register
    logic              r_o_valid;
    logic [VAL_W-1:0]  r_o_value;
    logic [SLOT_W-1:0] r_o_slot;
    t_status           r_o_status;

    // memory ports
    logic                 lk_we, lk_re;
    logic [SW-1:0]        lk_wa, lk_ra;
    logic [LW-1:0]        lk_wd, lk_rd;
    logic                 vm_we, vm_re;
    logic [SW-1:0]        vm_wa, vm_ra;
    logic [DATA_BITS-1:0] vm_wd, vm_rd;

    logic [SW-1:0] lk_next, lk_prev;
    logic [SW-1:0] ins_anchor, ext_p, ins_n;
    logic          slot_ok, ins_fresh, out_free, req_acc;
    t_status       dec_status;

    alm_ram #(.WIDTH(LW), .DEPTH(NODE_SLOTS)) u_link_ram (
        .i_clk     (i_clk),
        .i_wr_en   (lk_we),
        .i_wr_addr (lk_wa),
        .i_wr_data (lk_wd),
        .i_rd_en   (lk_re),
        .i_rd_addr (lk_ra),
        .o_rd_data (lk_rd)
    );

    alm_ram #(.WIDTH(DATA_BITS), .DEPTH(NODE_SLOTS)) u_value_ram (
        .i_clk     (i_clk),
        .i_wr_en   (vm_we),
        .i_wr_addr (vm_wa),
        .i_wr_data (vm_wd),
        .i_rd_en   (vm_re),
        .i_rd_addr (vm_ra),
        .o_rd_data (vm_rd)
    );

    assign lk_next = lk_rd[SW-1:0];
    assign lk_prev = lk_rd[LW-1:SW];

    assign req_acc  = i_req.valid && i_req.ready;
    assign out_free = !r_o_valid || o_rsp.ready;

    // hold off requests while reset is applied
    assign i_req.ready     = i_rst_n && (r_state == S_IDLE);
    assign o_rsp.valid     = r_o_valid;
    assign o_rsp.out_value = r_o_value;
    assign o_rsp.out_slot  = r_o_slot;
    assign o_rsp.status    = r_o_status;

    // Request checks, all from registered state.
    assign slot_ok    = (int'(r_slot) < NODE_SLOTS) && r_iu[r_slot[IUW-1:0]];
    assign ins_anchor = (t_req'(r_type) == REQ_INS_TAIL) ? r_tail : SW'(r_slot);
    assign ins_fresh  = int'(r_free) >= int'(r_hwm);
    assign ins_n      = (r_a != '0) ? lk_next : r_head;

    always_comb begin
        ext_p = SW'(r_slot);
        if (t_req'(r_type) == REQ_EXT_HEAD) begin
            ext_p = r_head;
        end else if (t_req'(r_type) == REQ_EXT_TAIL) begin
            ext_p = r_tail;
        end
    end

    always_comb begin
        dec_status = ST_OK;
        unique case (t_req'(r_type))
            REQ_INS_AFTER, REQ_INS_TAIL: begin
                if (r_free == '0) begin
                    dec_status = ST_FULL;
                end else if (t_req'(r_type) == REQ_INS_AFTER && r_slot != '0 && !slot_ok) begin
                    dec_status = ST_BAD;
                end
            end
            REQ_EXT_SLOT, REQ_EXT_HEAD, REQ_EXT_TAIL: begin
                if (r_count == '0) begin
                    dec_status = ST_EMPTY;
                end else if (t_req'(r_type) == REQ_EXT_SLOT && (r_slot == '0 || !slot_ok)) begin
                    dec_status = ST_BAD;
                end
            end
            REQ_LOCATE: begin
                if (r_count == '0) begin
                    dec_status = ST_EMPTY;
                end else if (r_pos == '0 || int'(r_pos) > int'(r_count)) begin
                    dec_status = ST_BAD;
                end
            end
            default: dec_status = ST_BAD;
        endcase
    end

    // Sequencer: next state and memory commands.
    always_comb begin
        n_state = r_state;
        lk_we   = 1'b0;
        lk_wa   = r_a;
        lk_wd   = '0;
        lk_re   = 1'b0;
        lk_ra   = r_a;
        vm_we   = 1'b0;
        vm_wa   = r_free;
        vm_wd   = r_data;
        vm_re   = 1'b0;
        vm_ra   = r_a;
        unique case (r_state)
            S_IDLE: begin
                if (req_acc) begin
                    n_state = S_DEC;
                end
            end
            S_DEC: begin
                if (dec_status != ST_OK) begin
                    n_state = S_FIN;
                end else begin
                    unique case (t_req'(r_type))
                        REQ_INS_AFTER, REQ_INS_TAIL: begin
                            lk_re   = 1'b1;
                            lk_ra   = r_free;
                            vm_we   = 1'b1;
                            n_state = S_INS_F;
                        end
                        REQ_EXT_SLOT, REQ_EXT_HEAD, REQ_EXT_TAIL: begin
                            lk_re   = 1'b1;
                            lk_ra   = ext_p;
                            vm_re   = 1'b1;
                            vm_ra   = ext_p;
                            n_state = S_EXT_N;
                        end
                        default: n_state = S_LOC;
                    endcase
                end
            end
            S_INS_F: begin
                if (r_a != '0) begin
                    lk_re = 1'b1;
                    lk_ra = r_a;
                end
                n_state = S_INS_A;
            end
            S_INS_A: begin
                // point the anchor at the new slot, fetch the old successor
                if (r_a != '0) begin
                    lk_we = 1'b1;
                    lk_wa = r_a;
                    lk_wd = {lk_prev, r_free};
                end
                if (ins_n != '0) begin
                    lk_re = 1'b1;
                    lk_ra = ins_n;
                end
                n_state = S_INS_N;
            end
            S_INS_N: begin
                if (r_n != '0) begin
                    lk_we = 1'b1;
                    lk_wa = r_n;
                    lk_wd = {r_free, lk_next};
                end
                n_state = S_INS_W;
            end
            S_INS_W: begin
                lk_we   = 1'b1;
                lk_wa   = r_free;
                lk_wd   = {r_a, r_n};
                n_state = S_FIN;
            end
            S_EXT_N: begin
                // push the removed slot onto the free chain, fetch its successor
                lk_we = 1'b1;
                lk_wa = r_a;
                lk_wd = {{SW{1'b0}}, r_free};
                if (lk_next != '0) begin
                    lk_re = 1'b1;
                    lk_ra = lk_next;
                end
                n_state = S_EXT_P;
            end
            S_EXT_P: begin
                if (r_n != '0) begin
                    lk_we = 1'b1;
                    lk_wa = r_n;
                    lk_wd = {r_pr, lk_next};
                end
                if (r_pr != '0) begin
                    lk_re = 1'b1;
                    lk_ra = r_pr;
                end
                n_state = S_EXT_Q;
            end
            S_EXT_Q: begin
                if (r_pr != '0) begin
                    lk_we = 1'b1;
                    lk_wa = r_pr;
                    lk_wd = {lk_prev, r_n};
                end
                n_state = S_FIN;
            end
            S_LOC: begin
                if (r_steps == '0) begin
                    vm_re   = 1'b1;
                    vm_ra   = r_ptr;
                    n_state = S_LOC_VAL;
                end else begin
                    lk_re   = 1'b1;
                    lk_ra   = r_ptr;
                    n_state = S_LOC_NXT;
                end
            end
            S_LOC_NXT: begin
                // chase one link per cycle straight from the read data
                if (r_steps == POS_W'(1)) begin
                    vm_re   = 1'b1;
                    vm_ra   = lk_next;
                    n_state = S_LOC_VAL;
                end else begin
                    lk_re = 1'b1;
                    lk_ra = lk_next;
                end
            end
            S_LOC_VAL: n_state = S_FIN;
            S_FIN: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // List bookkeeping and output valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head    <= '0;
            r_tail    <= '0;
            r_free    <= SW'(1);
            r_count   <= '0;
            r_hwm     <= HW'(1);
            r_iu      <= '0;
            r_o_valid <= 1'b0;
        end else begin
            unique case (r_state)
                S_INS_W: begin
                    if (r_n == '0) begin
                        r_tail <= r_free;
                    end
                    if (r_a == '0) begin
                        r_head <= r_free;
                    end
                    r_free  <= r_nfree;
                    r_count <= r_count + CW'(1);
                    if (int'(r_free) < IU) begin
                        r_iu[r_free[IUW-1:0]] <= 1'b1;
                    end
                    if (r_fresh) begin
                        r_hwm <= HW'(int'(r_free) + 1);
                    end
                end
                S_EXT_Q: begin
                    if (r_n == '0) begin
                        r_tail <= r_pr;
                    end
                    if (r_pr == '0) begin
                        r_head <= r_n;
                    end
                    r_free  <= r_a;
                    r_count <= r_count - CW'(1);
                    if (int'(r_a) < IU) begin
                        r_iu[r_a[IUW-1:0]] <= 1'b0;
                    end
                end
                default: ;
            endcase
            if (r_state == S_FIN && out_free) begin
                r_o_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    // Payload and working registers.
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                if (req_acc) begin
                    r_type <= i_req.req_type;
                    r_data <= i_req.data_value[DATA_BITS-1:0];
                    r_slot <= i_req.slot;
                    r_pos  <= i_req.position;
                end
            end
            S_DEC: begin
                r_res_status <= dec_status;
                r_res_value  <= '0;
                r_res_slot   <= '0;
                r_a          <= (t_req'(r_type) == REQ_INS_AFTER ||
                                 t_req'(r_type) == REQ_INS_TAIL) ? ins_anchor : ext_p;
                r_ptr        <= r_head;
                r_steps      <= r_pos - POS_W'(1);
            end
            S_INS_F: begin
                // a never-used slot still chains to its neighbor
                r_fresh <= ins_fresh;
                if (ins_fresh) begin
                    r_nfree <= (int'(r_free) == NODE_SLOTS - 1) ? '0
                                                                : SW'(int'(r_free) + 1);
                end else begin
                    r_nfree <= lk_next;
                end
            end
            S_INS_A: r_n <= ins_n;
            S_INS_W: r_res_slot <= SLOT_W'(r_free);
            S_EXT_N: begin
                r_n         <= lk_next;
                r_pr        <= lk_prev;
                r_res_value <= VAL_W'(vm_rd);
            end
            S_EXT_Q: r_res_slot <= SLOT_W'(r_a);
            S_LOC_NXT: begin
                r_ptr   <= lk_next;
                r_steps <= r_steps - POS_W'(1);
            end
            S_LOC_VAL: begin
                r_res_value <= VAL_W'(vm_rd);
                r_res_slot  <= SLOT_W'(r_ptr);
            end
            S_FIN: begin
                if (out_free) begin
                    r_o_value  <= r_res_value;
                    r_o_slot   <= r_res_slot;
                    r_o_status <= r_res_status;
                end
            end
            default: ;
        endcase
    end

    a_free_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_free == '0) == (int'(r_count) == NODE_SLOTS - 1))
        else $error("free chain empty does not match full count");

    a_ends_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_head == '0) == (r_count == '0)) && ((r_tail == '0) == (r_count == '0)))
        else $error("head or tail disagrees with element count");

    a_iu_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(r_iu) <= int'(r_count))
        else $error("more in-use flags than elements");

    a_one_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FIN && out_free) |=> (r_o_valid && r_state == S_IDLE))
        else $error("result not delivered exactly once");

endmodule

// File: design/alm_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Read data holds while no read is issued; reads return old data on collision.
module alm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;
endmodule
